// ----- rtl/csp_pkg.sv -----
// Shared constants, types and coefficient tables of the cubic surface position map.
package csp_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int TERMS_PER_AXIS = 4;
    localparam int FRAC_BITS      = 8;

    localparam int COEF_FRAC = 48;
    localparam int OUT_SHIFT = COEF_FRAC - FRAC_BITS;
    localparam int COEF_W    = 64;
    localparam int CHI_W     = COEF_W + 1 - 32;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int MONO_W    = 3 * SAMPLE_BITS;
    localparam int LO_W      = MONO_W + 32;
    localparam int HI_W      = MONO_W + CHI_W + 1;
    localparam int ACC_W     = MONO_W + 70;
    localparam int POS_W     = 32;

    localparam int NUM_TERMS = 10;
    localparam int NUM_AXES  = 2;
    localparam int AXIS_X    = 0;
    localparam int AXIS_Y    = 1;

    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = NUM_AXES * POS_W;

    // Pipeline stage positions.
    localparam int ST_IN      = 0;
    localparam int ST_MONO    = 1;
    localparam int ST_PPROD   = 2;
    localparam int ST_TERM    = 3;
    localparam int ST_SUM1    = 4;
    localparam int ST_SUM2    = 5;
    localparam int ST_SUM3    = 6;
    localparam int ST_SUM4    = 7;
    localparam int ST_OUT     = 8;
    localparam int NUM_STAGES = 9;

    typedef logic [SAMPLE_BITS-1:0]   sample_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [MONO_W-1:0]        mono_t;
    typedef logic [LO_W-1:0]          lo_prod_t;
    typedef logic signed [HI_W-1:0]   hi_prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [COEF_W:0]   coef_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } csp_ctrl_t;

    // Exponents of a and b for each term, in the order the monomials are built.
    localparam int unsigned TERM_I [NUM_TERMS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int unsigned TERM_J [NUM_TERMS] = '{0, 1, 2, 3, 0, 1, 2, 0, 1, 0};

    // Decimal coefficient mant / 10^dexp turned into signed Q48, rounded half away
    // from zero. Terms outside the configured order come out as zero.
    function automatic coef_t coef_fix(input logic [63:0] mant, input int unsigned dexp,
                                       input logic neg, input int unsigned t);
        logic [127:0]  v;
        logic [COEF_W:0] mag;
        int unsigned   k;
        v = {64'd0, mant} << (COEF_FRAC + 1);
        for (k = 0; k < dexp; k++) begin
            v = v / 128'd10;
        end
        v = v + 128'd1;
        mag = {1'b0, v[COEF_W:1]};
        if (TERM_I[t] >= TERMS_PER_AXIS || TERM_J[t] >= TERMS_PER_AXIS) begin
            mag = '0;
        end
        return neg ? coef_t'(~mag + 1'b1) : coef_t'(mag);
    endfunction

    localparam coef_t COEF_TAB [NUM_AXES][NUM_TERMS] = '{
        '{
            coef_fix(64'd4567859109016506,  12, 1'b0, 0),
            coef_fix(64'd12070032428600754, 15, 1'b1, 1),
            coef_fix(64'd10447127582831,    15, 1'b0, 2),
            coef_fix(64'd2931213502668813,  21, 1'b1, 3),
            coef_fix(64'd4804017457787141,  15, 1'b1, 4),
            coef_fix(64'd9751051028361,     15, 1'b0, 5),
            coef_fix(64'd5006132181913513,  21, 1'b1, 6),
            coef_fix(64'd5136964949169,     15, 1'b1, 7),
            coef_fix(64'd4091042992890025,  21, 1'b0, 8),
            coef_fix(64'd1652366564557850,  21, 1'b0, 9)
        },
        '{
            coef_fix(64'd1760359099168356,  11, 1'b0, 0),
            coef_fix(64'd39460913770597486, 15, 1'b1, 1),
            coef_fix(64'd29171985684019,    15, 1'b0, 2),
            coef_fix(64'd7093508584157673,  21, 1'b1, 3),
            coef_fix(64'd5485701903673827,  14, 1'b1, 4),
            coef_fix(64'd9159038173238,     14, 1'b0, 5),
            coef_fix(64'd3831345502089454,  20, 1'b1, 6),
            coef_fix(64'd31144401943405,    15, 1'b0, 7),
            coef_fix(64'd2801513461694372,  20, 1'b1, 8),
            coef_fix(64'd1662851774514397,  21, 1'b1, 9)
        }
    };

endpackage

// ----- rtl/cubic_surface_position_map_unit.sv -----
// Nine register stages (squares, monomials, partial products, term sums, four adder tree
// levels, rounding and saturation); one beat per cycle while the output does not stall.
// A stalled output holds its beat while earlier stages keep filling their empty slots.
// Reset (synchronous, active low) clears every stage valid bit; data registers keep values.
module cubic_surface_position_map_unit import csp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // sample_a, sample_b
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // position_x, position_y
);

    csp_ctrl_t ctrl;
    sample_t   sample_a;
    sample_t   sample_b;
    mono_t     mono [NUM_TERMS];
    acc_t      term [NUM_AXES][NUM_TERMS];
    pos_t      pos  [NUM_AXES];

    assign sample_a = s_tdata[SAMPLE_BITS-1:0];
    assign sample_b = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    csp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    csp_mono u_mono (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .sample_a (sample_a),
        .sample_b (sample_b),
        .mono     (mono)
    );

    csp_term u_term (
        .aclk (aclk),
        .ctrl (ctrl),
        .mono (mono),
        .term (term)
    );

    csp_sum u_sum (
        .aclk (aclk),
        .ctrl (ctrl),
        .term (term),
        .pos  (pos)
    );

    assign m_tdata = {pos[AXIS_Y], pos[AXIS_X]};

endmodule

// ----- rtl/csp_ctrl.sv -----
// Valid bits and per-stage load enables of the position map pipeline.
module csp_ctrl import csp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output csp_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // A stage takes new data when it is empty or its contents move on this cycle.
    always_comb begin
        load[ST_OUT] = !valid_reg[ST_OUT] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load[ST_IN]) begin
            valid_next[ST_IN] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = load;
    assign s_tready  = load[ST_IN];
    assign m_tvalid  = valid_reg[ST_OUT];

endmodule

// ----- rtl/csp_mono.sv -----
// Input register, squares and the ten monomials a^i * b^j with i + j <= 3.
module csp_mono import csp_pkg::*; (
    input  logic      aclk,
    input  csp_ctrl_t ctrl,
    input  sample_t   sample_a,
    input  sample_t   sample_b,
    output mono_t     mono [NUM_TERMS]
);

    sample_t a_reg;
    sample_t b_reg;
    sq_t     a2_reg;
    sq_t     ab_reg;
    sq_t     b2_reg;
    mono_t   mono_reg  [NUM_TERMS];
    mono_t   mono_next [NUM_TERMS];

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_IN]) begin
            a_reg  <= sample_a;
            b_reg  <= sample_b;
            a2_reg <= SQ_W'(sample_a) * SQ_W'(sample_a);
            ab_reg <= SQ_W'(sample_a) * SQ_W'(sample_b);
            b2_reg <= SQ_W'(sample_b) * SQ_W'(sample_b);
        end
    end

    // Order follows TERM_I / TERM_J in the package.
    always_comb begin
        mono_next[0] = MONO_W'(1);
        mono_next[1] = MONO_W'(b_reg);
        mono_next[2] = MONO_W'(b2_reg);
        mono_next[3] = MONO_W'(b2_reg) * MONO_W'(b_reg);
        mono_next[4] = MONO_W'(a_reg);
        mono_next[5] = MONO_W'(ab_reg);
        mono_next[6] = MONO_W'(ab_reg) * MONO_W'(b_reg);
        mono_next[7] = MONO_W'(a2_reg);
        mono_next[8] = MONO_W'(a2_reg) * MONO_W'(b_reg);
        mono_next[9] = MONO_W'(a2_reg) * MONO_W'(a_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_MONO]) begin
            mono_reg <= mono_next;
        end
    end

    assign mono = mono_reg;

endmodule

// ----- rtl/csp_term.sv -----
// Coefficient products: two partial products per term, then their exact sum.
module csp_term import csp_pkg::*; (
    input  logic      aclk,
    input  csp_ctrl_t ctrl,
    input  mono_t     mono [NUM_TERMS],
    output acc_t      term [NUM_AXES][NUM_TERMS]
);

    lo_prod_t lo_reg   [NUM_AXES][NUM_TERMS];
    lo_prod_t lo_next  [NUM_AXES][NUM_TERMS];
    hi_prod_t hi_reg   [NUM_AXES][NUM_TERMS];
    hi_prod_t hi_next  [NUM_AXES][NUM_TERMS];
    acc_t     term_reg [NUM_AXES][NUM_TERMS];
    acc_t     term_next[NUM_AXES][NUM_TERMS];

    // The signed coefficient is split into an unsigned low word and a signed high part.
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                lo_next[ax][t] = LO_W'(mono[t]) * LO_W'(COEF_TAB[ax][t][31:0]);
                hi_next[ax][t] = $signed(HI_W'(mono[t]))
                               * $signed({{(HI_W-CHI_W){COEF_TAB[ax][t][COEF_W]}},
                                          COEF_TAB[ax][t][COEF_W:32]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_PPROD]) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                term_next[ax][t] = (ACC_W'(hi_reg[ax][t]) <<< 32)
                                 + $signed(ACC_W'(lo_reg[ax][t]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_TERM]) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// ----- rtl/csp_sum.sv -----
// Registered adder tree over the terms of each axis, then rounding and saturation.
module csp_sum import csp_pkg::*; (
    input  logic      aclk,
    input  csp_ctrl_t ctrl,
    input  acc_t      term [NUM_AXES][NUM_TERMS],
    output pos_t      pos  [NUM_AXES]
);

    localparam int L1 = (NUM_TERMS + 1) / 2;
    localparam int L2 = (L1 + 1) / 2;
    localparam int L3 = (L2 + 1) / 2;

    localparam acc_t HALF    = acc_t'(1) <<< (OUT_SHIFT - 1);
    localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam int   TOP_LO  = OUT_SHIFT + POS_W - 1;

    acc_t l1_reg  [NUM_AXES][L1];
    acc_t l1_next [NUM_AXES][L1];
    acc_t l2_reg  [NUM_AXES][L2];
    acc_t l2_next [NUM_AXES][L2];
    acc_t l3_reg  [NUM_AXES][L3];
    acc_t l3_next [NUM_AXES][L3];
    acc_t sum_reg [NUM_AXES];
    acc_t sum_next[NUM_AXES];
    pos_t pos_reg [NUM_AXES];
    pos_t pos_next[NUM_AXES];

    // An odd entry at the end of a level passes through; its partner index is kept in range.
    always_comb begin
        int odd_k;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            for (int k = 0; k < L1; k++) begin
                l1_next[ax][k] = (2 * k + 1 < NUM_TERMS)
                               ? term[ax][2*k] + term[ax][2*k+1] : term[ax][2*k];
            end
            for (int k = 0; k < L2; k++) begin
                odd_k = (2 * k + 1 < L1) ? 2 * k + 1 : 2 * k;
                l2_next[ax][k] = (2 * k + 1 < L1)
                               ? l1_reg[ax][2*k] + l1_reg[ax][odd_k] : l1_reg[ax][2*k];
            end
            for (int k = 0; k < L3; k++) begin
                odd_k = (2 * k + 1 < L2) ? 2 * k + 1 : 2 * k;
                l3_next[ax][k] = (2 * k + 1 < L2)
                               ? l2_reg[ax][2*k] + l2_reg[ax][odd_k] : l2_reg[ax][2*k];
            end
            sum_next[ax] = l3_reg[ax][0] + l3_reg[ax][L3-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_SUM1]) begin
            l1_reg <= l1_next;
        end
        if (ctrl.load[ST_SUM2]) begin
            l2_reg <= l2_next;
        end
        if (ctrl.load[ST_SUM3]) begin
            l3_reg <= l3_next;
        end
        if (ctrl.load[ST_SUM4]) begin
            sum_reg <= sum_next;
        end
    end

    // Round half up, then clamp when the bits above the result are not a sign extension.
    always_comb begin
        acc_t                   rnd;
        logic [ACC_W-1:TOP_LO]  top;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            rnd = sum_reg[ax] + HALF;
            top = rnd[ACC_W-1:TOP_LO];
            if (&top || ~|top) begin
                pos_next[ax] = rnd[TOP_LO:OUT_SHIFT];
            end else begin
                pos_next[ax] = rnd[ACC_W-1] ? POS_MIN : POS_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_OUT]) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

// ----- rtl/csp_checker.sv -----
// Port-level checks of the position map pipeline, bound to the top level.
module csp_checker import csp_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // No result beat is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // A stalled result beat stays and keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // With the output side ready, the pipeline never pushes back on the input.
    a_no_backpressure: assert property (@(posedge aclk)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // An accepted beat reaches the output when m_tready stays high in between.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result beat missing after pipeline latency");

endmodule

bind cubic_surface_position_map_unit csp_checker u_csp_checker (.*);

// ----- tb/csp_position_checker.sv -----
// Checker for the cubic surface position map: predicts each position pair and compares it.
`timescale 1ns / 100ps

module csp_position_checker import csp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // sample_a, sample_b
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,    // position_x, position_y
    output int                  fail_count,
    output int                  outstanding
);

    localparam int NTERMS = 10;

    typedef struct packed {
        pos_t x;
        pos_t y;
    } position_pair_t;

    // Each coefficient is mant / 10^dexp, negated when neg is set.
    // Terms run in the order 1, b, b^2, b^3, a, ab, ab^2, a^2, a^2 b, a^3.
    localparam int unsigned POW_A [NTERMS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int unsigned POW_B [NTERMS] = '{0, 1, 2, 3, 0, 1, 2, 0, 1, 0};

    localparam longint unsigned MANT [2][NTERMS] = '{
        '{64'd4567859109016506, 64'd12070032428600754, 64'd10447127582831,
          64'd2931213502668813, 64'd4804017457787141, 64'd9751051028361,
          64'd5006132181913513, 64'd5136964949169, 64'd4091042992890025,
          64'd1652366564557850},
        '{64'd1760359099168356, 64'd39460913770597486, 64'd29171985684019,
          64'd7093508584157673, 64'd5485701903673827, 64'd9159038173238,
          64'd3831345502089454, 64'd31144401943405, 64'd2801513461694372,
          64'd1662851774514397}
    };
    localparam int unsigned DEXP [2][NTERMS] = '{
        '{12, 15, 15, 21, 15, 15, 21, 15, 21, 21},
        '{11, 15, 15, 21, 14, 14, 20, 15, 20, 21}
    };
    localparam bit NEG [2][NTERMS] = '{
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}
    };

    logic signed [127:0] coef_q48 [2][NTERMS];
    position_pair_t      pending_positions [$];

    // Signed Q48 coefficients, rounded half away from zero from the decimal values.
    initial begin
        logic [127:0] v;
        for (int ax = 0; ax < 2; ax++) begin
            for (int t = 0; t < NTERMS; t++) begin
                v = {64'd0, MANT[ax][t]} << (COEF_FRAC + 1);
                for (int k = 0; k < DEXP[ax][t]; k++) begin
                    v = v / 128'd10;
                end
                v = (v + 128'd1) >> 1;
                coef_q48[ax][t] = NEG[ax][t] ? -$signed(v) : $signed(v);
            end
        end
    end

    function automatic pos_t axis_position(input int ax, input sample_t a, input sample_t b);
        logic signed [127:0] acc;
        logic signed [127:0] mono;
        acc = '0;
        for (int t = 0; t < NTERMS; t++) begin
            if (coef_q48[ax][t] == 0 || POW_A[t] >= TERMS_PER_AXIS ||
                POW_B[t] >= TERMS_PER_AXIS) begin
                continue;
            end
            mono = 128'sd1;
            for (int k = 0; k < POW_A[t]; k++) mono = mono * $signed({116'd0, a});
            for (int k = 0; k < POW_B[t]; k++) mono = mono * $signed({116'd0, b});
            acc = acc + coef_q48[ax][t] * mono;
        end
        // Round to the output fraction with a half going up, then clamp to 32 bits.
        acc = (acc + (128'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (acc > 128'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (acc < -128'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return pos_t'(acc[31:0]);
    endfunction

    always @(posedge aclk) begin
        position_pair_t want;
        position_pair_t got;
        bit             in_beat;
        bit             out_beat;
        if (!aresetn) begin
            fail_count  <= 0;
            outstanding <= 0;
            pending_positions.delete();
        end else begin
            in_beat  = s_tvalid && s_tready;
            out_beat = m_tvalid && m_tready;
            if (in_beat) begin
                want.x = axis_position(AXIS_X, s_tdata[SAMPLE_BITS-1:0],
                                       s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                want.y = axis_position(AXIS_Y, s_tdata[SAMPLE_BITS-1:0],
                                       s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                pending_positions.push_back(want);
            end
            if (out_beat) begin
                got.x = m_tdata[POS_W-1:0];
                got.y = m_tdata[2*POS_W-1:POS_W];
                if (pending_positions.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result beat x=%0d y=%0d with nothing expected",
                                 $realtime, got.x, got.y);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = pending_positions.pop_front();
                    if (got.x !== want.x || got.y !== want.y) begin
                        if (fail_count < 10) begin
                            $display("%0t: position mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     $realtime, want.x, want.y, got.x, got.y);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= pending_positions.size();
        end
    end

endmodule

// ----- tb/tb_cubic_surface_position_map_unit.sv -----
// Top of the testbench: clock, reset, sample stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module tb_cubic_surface_position_map_unit;
    import csp_pkg::*;

    localparam int RANDOM_PAIRS = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 700;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 80;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int pairs_sent = 0;
    int cycles = 0;
    bit run_started = 1'b0;

    cubic_surface_position_map_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    csp_position_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL cubic_surface_position_map_unit");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return pairs_sent >= QUIET_FROM && pairs_sent < QUIET_TO;
    endfunction

    function automatic sample_t random_sample();
        sample_t corners [7] = '{12'h000, 12'h001, 12'h002, 12'h7FF, 12'h800, 12'hFFE, 12'hFFF};
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            return sample_t'($urandom_range(0, 4095));
        end else if (pick <= 7) begin
            return corners[$urandom_range(0, 6)];
        end
        // A single set or single cleared bit.
        return (pick == 8) ? sample_t'(1 << $urandom_range(0, SAMPLE_BITS - 1))
                           : ~sample_t'(1 << $urandom_range(0, SAMPLE_BITS - 1));
    endfunction

    task automatic send_pair(input sample_t a, input sample_t b);
        if (!quiet_window()) begin
            while ($urandom_range(0, 99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= S_DATA_W'({b, a});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pairs_sent++;
    endtask

    // Output side: random stalls, a quiet stretch, and one long hold-off that backs up the pipe.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (run_started);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && pairs_sent >= HOLD_AT) begin
                m_tready <= 1'b0;
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (quiet_window()) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    initial begin
        sample_t edge_a [14] = '{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'h001,
                                 12'hFFF, 12'h001, 12'hAAA, 12'h555, 12'h800, 12'h000, 12'h123};
        sample_t edge_b [14] = '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h800, 12'h7FF, 12'h001,
                                 12'h001, 12'hFFF, 12'h555, 12'hAAA, 12'h000, 12'h800, 12'hEDC};
        int settle;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_started = 1'b1;

        for (int i = 0; i < 14; i++) begin
            send_pair(edge_a[i], edge_b[i]);
        end
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            send_pair(random_sample(), random_sample());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // Let any stray beat from the nine-stage pipeline show up.
        for (settle = 0; settle < 30; settle++) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS cubic_surface_position_map_unit");
        end else begin
            $display("FAIL cubic_surface_position_map_unit");
        end
        $finish;
    end

endmodule
